// ===== hdl/palette_hue_saturation_shift_assert.svh =====
// ----------------------------------------------------------------------------
// Palette hue/saturation shift assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef PALETTE_HUE_SATURATION_SHIFT_ASSERT_SVH
`define PALETTE_HUE_SATURATION_SHIFT_ASSERT_SVH

// Same-cycle implication.
`define PHSS_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error("phss: assertion failed");

// Next-cycle implication.
`define PHSS_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error("phss: assertion failed");

`endif

// ===== hdl/phss_pkg.sv =====
// ----------------------------------------------------------------------------
// Palette hue/saturation shift package
// Item types, register indexes, fixed-point constants and helper functions.
// ----------------------------------------------------------------------------
package phss_pkg;

	typedef struct packed {
		logic [7:0]  entry_index;
		logic [31:0] color_word;
	} entry_t;

	typedef struct packed {
		logic [31:0] result_word;
		logic        was_changed;
	} result_t;

	localparam logic [0:0] REG_TARGET_HUE      = 1'd0;
	localparam logic [0:0] REG_SATURATION_GAIN = 1'd1;

	localparam logic [11:0] HUE_RESET  = 12'd300;
	localparam logic [11:0] HUE_CIRCLE = 12'd3600;
	localparam logic [9:0]  GAIN_ONE   = 10'd256;
	localparam logic [9:0]  GAIN_MAX   = 10'd512;

	localparam logic [7:0] BAND_LO  = 8'd224;
	localparam logic [7:0] BAND_HI  = 8'd239;
	localparam logic [7:0] EXTRA_LO = 8'd252;
	localparam logic [7:0] EXTRA_HI = 8'd253;

	// Hue is in tenths of a degree times 256.
	localparam int unsigned DIV_STEPS = 20;
	localparam logic [17:0] HUE_SECTOR = 18'd153600;
	localparam logic [19:0] HUE_FULL   = 20'd921600;
	localparam logic [21:0] HUE_FULL2  = 22'd1843200;
	localparam logic [21:0] HUE_OFFSET = 22'd844800;
	localparam logic [16:0] SAT_ONE    = 17'd65536;

	// 65536 * 153600 = 2^27 * 75.
	localparam logic [33:0] SCALE_DEN  = 34'd10066329600;
	localparam logic [41:0] SCALE_HALF = 42'd5033164800;
	localparam logic [15:0] RECIP_75   = 16'd55925;

	function automatic logic in_band(input logic [7:0] idx);
		return (idx >= BAND_LO && idx <= BAND_HI) || idx == EXTRA_LO || idx == EXTRA_HI;
	endfunction

	// One restoring division step: remainder, then dividend bits shifted for quotient bits.
	function automatic logic [27:0] div_step(input logic [7:0] rem, input logic [19:0] acc,
			input logic [7:0] dvs);
		logic [8:0] t;
		t = {rem, acc[19]};
		if (t >= {1'b0, dvs}) begin
			return {8'(t - {1'b0, dvs}), acc[18:0], 1'b1};
		end else begin
			return {t[7:0], acc[18:0], 1'b0};
		end
	endfunction

endpackage

// ===== hdl/palette_hue_saturation_shift.sv =====
// ----------------------------------------------------------------------------
// Palette hue/saturation shift
// Recolors a band of palette entries through HSV with a hue rotation and a
// saturation gain; all other entries pass through.
// ----------------------------------------------------------------------------
// Usage:
// Items enter on entry/entry_valid and leave on result/result_valid. An item
// moves at a clock edge where valid is high and stall is low. Every accepted
// entry gives exactly one result, in order.
// The pipeline takes one item per cycle while result_stall does not hold it.
// Most of its depth is set by the two 20-step restoring dividers
// (hue and saturation) that run side by side, one quotient bit per stage.
// When result_stall is high with a result waiting, the whole pipeline holds
// and entry_stall is raised in the same cycle; nothing is lost or repeated.
// Registers are written over cfg_valid/cfg_ready with cfg_index and cfg_data;
// cfg_ready is always high. Write them only while no item is in flight.
// Reset empties the pipeline and sets target hue 30.0 degrees and gain 1.0.
// ----------------------------------------------------------------------------
`include "palette_hue_saturation_shift_assert.svh"

module palette_hue_saturation_shift (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              entry_valid,
	output logic              entry_stall,
	input  phss_pkg::entry_t  entry,
	output logic              result_valid,
	input  logic              result_stall,
	output phss_pkg::result_t result,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [0:0]        cfg_index,
	input  logic [11:0]       cfg_data
);
	import phss_pkg::*;

	logic [11:0] hue_q;
	logic [9:0]  gain_q;
	logic        neutral;
	logic        adv;

	// Stage 1: captured entry.
	logic        vld_s1;
	logic        act_s1;
	logic [31:0] word_s1;

	// Stage 2 group: element 0 is setup, elements 1..DIV_STEPS are divider steps.
	logic        vld_s2  [0:DIV_STEPS];
	logic        act_s2  [0:DIV_STEPS];
	logic        blk_s2  [0:DIV_STEPS];
	logic [31:0] word_s2 [0:DIV_STEPS];
	logic [7:0]  v_s2    [0:DIV_STEPS];
	logic [7:0]  d_s2    [0:DIV_STEPS];
	logic [7:0]  hrem_s2 [0:DIV_STEPS];
	logic [19:0] hacc_s2 [0:DIV_STEPS];
	logic [7:0]  srem_s2 [0:DIV_STEPS];
	logic [19:0] sacc_s2 [0:DIV_STEPS];

	logic [7:0]  r_c, g_c, b_c, mx_c, mn_c, d_c;
	logic [10:0] units_c;
	logic [27:0] nh_c, ns_c;

	logic        vld_s3, act_s3, blk_s3;
	logic [31:0] word_s3;
	logic [7:0]  v_s3;
	logic [16:0] s_s3;
	logic [19:0] rot_s3;
	logic [19:0] h_c;
	logic [21:0] sum_c;
	logic [19:0] rot_c;
	logic [16:0] s_c;

	logic        vld_s4, act_s4, blk_s4;
	logic [31:0] word_s4;
	logic [7:0]  v_s4;
	logic [16:0] s_s4;
	logic [2:0]  sec_s4;
	logic [17:0] rem_s4;
	logic [2:0]  sec_c;
	logic [17:0] rem_c;

	logic        vld_s5, act_s5, blk_s5;
	logic [31:0] word_s5;
	logic [7:0]  v_s5;
	logic [2:0]  sec_s5;
	logic [33:0] wp_s5, wq_s5, wt_s5;

	logic        vld_s6, act_s6, blk_s6;
	logic [31:0] word_s6;
	logic [7:0]  v_s6;
	logic [2:0]  sec_s6;
	logic [41:0] xp_s6, xq_s6, xt_s6;

	logic        vld_s7, act_s7, blk_s7;
	logic [31:0] word_s7;
	logic [7:0]  v_s7;
	logic [2:0]  sec_s7;
	logic [14:0] yp_s7, yq_s7, yt_s7;
	logic [41:0] sp_c, sq_c, st_c;

	logic        vld_s8, act_s8, blk_s8;
	logic [31:0] word_s8;
	logic [7:0]  v_s8;
	logic [2:0]  sec_s8;
	logic [30:0] zp_s8, zq_s8, zt_s8;

	logic        vld_s9;
	result_t     res_s9;
	logic [8:0]  op_c, oq_c, ot_c;
	logic [7:0]  p_c, q_c, t_c, o0_c, o1_c, o2_c;
	result_t     res_c;

	// Configuration registers hold the effective values (hue wrapped, gain capped).
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hue_q  <= HUE_RESET;
			gain_q <= GAIN_ONE;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_TARGET_HUE: begin
					hue_q <= (cfg_data >= HUE_CIRCLE) ? cfg_data - HUE_CIRCLE : cfg_data;
				end
				REG_SATURATION_GAIN: begin
					gain_q <= (cfg_data[9:0] > GAIN_MAX) ? GAIN_MAX : cfg_data[9:0];
				end
				default: begin
				end
			endcase
		end
	end

	assign cfg_ready   = 1'b1;
	assign neutral     = (hue_q == HUE_RESET) && (gain_q == GAIN_ONE);
	assign adv         = !(result_valid && result_stall);
	assign entry_stall = !adv;

	// Valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
			vld_s8 <= 1'b0;
			vld_s9 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= entry_valid;
			vld_s3 <= vld_s2[DIV_STEPS];
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
			vld_s7 <= vld_s6;
			vld_s8 <= vld_s7;
			vld_s9 <= vld_s8;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			act_s1  <= in_band(entry.entry_index) && !neutral;
			word_s1 <= entry.color_word;
		end
	end

	// Setup: channel extremes and the two dividends.
	always_comb begin
		r_c  = word_s1[7:0];
		g_c  = word_s1[15:8];
		b_c  = word_s1[23:16];
		mx_c = r_c;
		mn_c = r_c;
		if (g_c > mx_c) mx_c = g_c;
		if (b_c > mx_c) mx_c = b_c;
		if (g_c < mn_c) mn_c = g_c;
		if (b_c < mn_c) mn_c = b_c;
		d_c = mx_c - mn_c;
		if (mx_c == r_c) begin
			units_c = (g_c >= b_c) ? 11'(g_c) - 11'(b_c)
				: 11'(d_c) * 11'd6 + 11'(g_c) - 11'(b_c);
		end else if (mx_c == g_c) begin
			units_c = 11'(d_c) * 11'd2 + 11'(b_c) - 11'(r_c);
		end else begin
			units_c = 11'(d_c) * 11'd4 + 11'(r_c) - 11'(g_c);
		end
		nh_c = 28'(units_c) * 28'(HUE_SECTOR) + 28'(d_c >> 1);
		ns_c = ((28'(d_c) * 28'(gain_q)) << 8) + 28'(mx_c >> 1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2[0] <= 1'b0;
		end else if (adv) begin
			vld_s2[0] <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			act_s2[0]  <= act_s1;
			blk_s2[0]  <= (mx_c == 8'd0);
			word_s2[0] <= word_s1;
			v_s2[0]    <= mx_c;
			d_s2[0]    <= d_c;
			hrem_s2[0] <= nh_c[27:20];
			hacc_s2[0] <= nh_c[19:0];
			srem_s2[0] <= ns_c[27:20];
			sacc_s2[0] <= ns_c[19:0];
		end
	end

	// Divider steps: one hue and one saturation quotient bit per stage.
	for (genvar k = 1; k <= DIV_STEPS; k++) begin : g_div
		logic [27:0] hstep, sstep;

		assign hstep = div_step(hrem_s2[k-1], hacc_s2[k-1], d_s2[k-1]);
		assign sstep = div_step(srem_s2[k-1], sacc_s2[k-1], v_s2[k-1]);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s2[k] <= 1'b0;
			end else if (adv) begin
				vld_s2[k] <= vld_s2[k-1];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				act_s2[k]  <= act_s2[k-1];
				blk_s2[k]  <= blk_s2[k-1];
				word_s2[k] <= word_s2[k-1];
				v_s2[k]    <= v_s2[k-1];
				d_s2[k]    <= d_s2[k-1];
				hrem_s2[k] <= hstep[27:20];
				hacc_s2[k] <= hstep[19:0];
				srem_s2[k] <= sstep[27:20];
				sacc_s2[k] <= sstep[19:0];
			end
		end
	end

	// Stage 3: saturation clamp and hue rotation with wrap.
	always_comb begin
		h_c   = (d_s2[DIV_STEPS] == 8'd0) ? 20'd0 : hacc_s2[DIV_STEPS];
		s_c   = (sacc_s2[DIV_STEPS] > 20'(SAT_ONE)) ? SAT_ONE : sacc_s2[DIV_STEPS][16:0];
		sum_c = 22'(h_c) + 22'({hue_q, 8'd0}) + HUE_OFFSET;
		if (sum_c >= HUE_FULL2) begin
			rot_c = 20'(sum_c - HUE_FULL2);
		end else if (sum_c >= 22'(HUE_FULL)) begin
			rot_c = 20'(sum_c - 22'(HUE_FULL));
		end else begin
			rot_c = sum_c[19:0];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			act_s3  <= act_s2[DIV_STEPS];
			blk_s3  <= blk_s2[DIV_STEPS];
			word_s3 <= word_s2[DIV_STEPS];
			v_s3    <= v_s2[DIV_STEPS];
			s_s3    <= s_c;
			rot_s3  <= rot_c;
		end
	end

	// Stage 4: sector and position within it.
	always_comb begin
		if (rot_s3 < 20'(HUE_SECTOR)) begin
			sec_c = 3'd0;
			rem_c = rot_s3[17:0];
		end else if (rot_s3 < 20'(HUE_SECTOR) * 20'd2) begin
			sec_c = 3'd1;
			rem_c = 18'(rot_s3 - 20'(HUE_SECTOR));
		end else if (rot_s3 < 20'(HUE_SECTOR) * 20'd3) begin
			sec_c = 3'd2;
			rem_c = 18'(rot_s3 - 20'(HUE_SECTOR) * 20'd2);
		end else if (rot_s3 < 20'(HUE_SECTOR) * 20'd4) begin
			sec_c = 3'd3;
			rem_c = 18'(rot_s3 - 20'(HUE_SECTOR) * 20'd3);
		end else if (rot_s3 < 20'(HUE_SECTOR) * 20'd5) begin
			sec_c = 3'd4;
			rem_c = 18'(rot_s3 - 20'(HUE_SECTOR) * 20'd4);
		end else begin
			sec_c = 3'd5;
			rem_c = 18'(rot_s3 - 20'(HUE_SECTOR) * 20'd5);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			act_s4  <= act_s3;
			blk_s4  <= blk_s3;
			word_s4 <= word_s3;
			v_s4    <= v_s3;
			s_s4    <= s_s3;
			sec_s4  <= sec_c;
			rem_s4  <= rem_c;
		end
	end

	// Stage 5: saturation times the hue fractions.
	always_ff @(posedge clk) begin
		if (adv) begin
			act_s5  <= act_s4;
			blk_s5  <= blk_s4;
			word_s5 <= word_s4;
			v_s5    <= v_s4;
			sec_s5  <= sec_s4;
			wp_s5   <= 34'(s_s4) * 34'(HUE_SECTOR);
			wq_s5   <= 34'(s_s4) * 34'(rem_s4);
			wt_s5   <= 34'(s_s4) * 34'(HUE_SECTOR - rem_s4);
		end
	end

	// Stage 6: value times the complement.
	always_ff @(posedge clk) begin
		if (adv) begin
			act_s6  <= act_s5;
			blk_s6  <= blk_s5;
			word_s6 <= word_s5;
			v_s6    <= v_s5;
			sec_s6  <= sec_s5;
			xp_s6   <= 42'(v_s5) * 42'(SCALE_DEN - wp_s5);
			xq_s6   <= 42'(v_s5) * 42'(SCALE_DEN - wq_s5);
			xt_s6   <= 42'(v_s5) * 42'(SCALE_DEN - wt_s5);
		end
	end

	// Stage 7: round half up and drop the power-of-two part of the scale.
	assign sp_c = xp_s6 + SCALE_HALF;
	assign sq_c = xq_s6 + SCALE_HALF;
	assign st_c = xt_s6 + SCALE_HALF;

	always_ff @(posedge clk) begin
		if (adv) begin
			act_s7  <= act_s6;
			blk_s7  <= blk_s6;
			word_s7 <= word_s6;
			v_s7    <= v_s6;
			sec_s7  <= sec_s6;
			yp_s7   <= sp_c[41:27];
			yq_s7   <= sq_c[41:27];
			yt_s7   <= st_c[41:27];
		end
	end

	// Stage 8: divide by 75 through its reciprocal.
	always_ff @(posedge clk) begin
		if (adv) begin
			act_s8  <= act_s7;
			blk_s8  <= blk_s7;
			word_s8 <= word_s7;
			v_s8    <= v_s7;
			sec_s8  <= sec_s7;
			zp_s8   <= 31'(yp_s7) * 31'(RECIP_75);
			zq_s8   <= 31'(yq_s7) * 31'(RECIP_75);
			zt_s8   <= 31'(yt_s7) * 31'(RECIP_75);
		end
	end

	// Stage 9: clamp, place channels by sector, assemble the result.
	always_comb begin
		op_c = zp_s8[30:22];
		oq_c = zq_s8[30:22];
		ot_c = zt_s8[30:22];
		p_c  = (op_c > 9'd255) ? 8'd255 : op_c[7:0];
		q_c  = (oq_c > 9'd255) ? 8'd255 : oq_c[7:0];
		t_c  = (ot_c > 9'd255) ? 8'd255 : ot_c[7:0];
		case (sec_s8)
			3'd0: begin o0_c = v_s8; o1_c = t_c;  o2_c = p_c;  end
			3'd1: begin o0_c = q_c;  o1_c = v_s8; o2_c = p_c;  end
			3'd2: begin o0_c = p_c;  o1_c = v_s8; o2_c = t_c;  end
			3'd3: begin o0_c = p_c;  o1_c = q_c;  o2_c = v_s8; end
			3'd4: begin o0_c = t_c;  o1_c = p_c;  o2_c = v_s8; end
			default: begin o0_c = v_s8; o1_c = p_c; o2_c = q_c; end
		endcase
		if (!act_s8) begin
			res_c.result_word = word_s8;
			res_c.was_changed = 1'b0;
		end else if (blk_s8) begin
			res_c.result_word = word_s8;
			res_c.was_changed = 1'b1;
		end else begin
			res_c.result_word = {word_s8[31:24], o2_c, o1_c, o0_c};
			res_c.was_changed = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_s9 <= res_c;
		end
	end

	assign result_valid = vld_s9;
	assign result       = res_s9;

	// The input side only waits on a held result.
	`PHSS_ASSERT_IMPL(a_stall_cause, entry_stall, result_valid)
	// Wrapped hue stays on the circle.
	`PHSS_ASSERT_IMPL(a_rot_range, vld_s3, rot_s3 < HUE_FULL)
	// Sector split leaves a position inside one sector.
	`PHSS_ASSERT_IMPL(a_sector_range, vld_s4, sec_s4 <= 3'd5 && rem_s4 < HUE_SECTOR)

	// Divider remainders stay below their divisors.
	for (genvar k = 0; k <= DIV_STEPS; k++) begin : g_div_chk
		`PHSS_ASSERT_IMPL(a_hrem, vld_s2[k] && d_s2[k] != 8'd0, hrem_s2[k] < d_s2[k])
		`PHSS_ASSERT_IMPL(a_srem, vld_s2[k] && v_s2[k] != 8'd0, srem_s2[k] < v_s2[k])
	end

endmodule
